[sv/pmsfr_pkg.sv]
// Shared constants and types for the particle sensor frame receiver.
package pmsfr_pkg;

    localparam logic [7:0] START_BYTE    = 8'h81;
    localparam logic [7:0] CMD_RESET     = 8'h12;
    localparam logic [3:0] BODY_LAST     = 4'd13;
    localparam logic [3:0] CONC_FIRST    = 4'd7;
    localparam logic [3:0] CONC_LAST     = 4'd12;
    localparam logic [3:0] STATUS_COUNT  = 4'd0;

    // Frame hunt phases.
    localparam logic [1:0] PH_HUNT       = 2'd0;
    localparam logic [1:0] PH_START      = 2'd1;
    localparam logic [1:0] PH_BODY       = 2'd2;

    // Register index of the command code.
    localparam logic       REG_COMMAND   = 1'b0;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [15:0] pm1_tenths;
        logic [15:0] pm25_tenths;
        logic [15:0] pm10_tenths;
        logic        checksum_ok;
    } t_result;

endpackage

[sv/pm_sensor_frame_receiver_top.sv]
// Top level of the particle sensor frame receiver: header hunt, body capture and checksum.
//
// The block takes one received serial byte per item on the rx channel and
// emits one result item per complete 16-byte frame: the status byte, the
// PM1, PM2.5 and PM10 concentrations in raw tenths of ug/m3, and a flag that
// is set when the byte sum of the frame is zero modulo 256. A frame starts
// with 0x81 followed by the command code register (reset 0x12, byte address
// 0 of the APB port); a repeated 0x81 keeps the half-matched header unless the
// command code is itself 0x81. Each byte passes through an input register and is
// decoded in the following cycle, so one byte is taken every clock cycle while
// the input does not stall, and a result is registered once its checksum byte is
// decoded. Input stalls only when a frame-ending byte finds the result register
// still occupied. Frames whose checksum fails are still delivered, with checksum_ok low.
module pm_sensor_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received byte channel.
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // Result channel.
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_status_byte,
    output logic [15:0] o_pm1_tenths,
    output logic [15:0] o_pm25_tenths,
    output logic [15:0] o_pm10_tenths,
    output logic        o_checksum_ok,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]              r_cmd;
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic [1:0]              r_phase,  n_phase;
    logic [3:0]              r_count,  n_count;
    logic [7:0]              r_sum,    n_sum;
    logic [7:0]              r_status, n_status;
    logic [47:0]             r_conc,   n_conc;
    logic                    r_res_valid;
    pmsfr_pkg::t_result      r_res,    n_res;

    logic emit;
    logic advance;
    logic cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == pmsfr_pkg::REG_COMMAND);
    assign prdata    = (paddr[2] == pmsfr_pkg::REG_COMMAND) ? {24'd0, r_cmd} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= pmsfr_pkg::CMD_RESET;
        end else if (cfg_write) begin
            r_cmd <= pwdata[7:0];
        end
    end

    // Decode of the registered byte.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_status = r_status;
        n_conc   = r_conc;
        emit     = 1'b0;
        n_res    = '0;
        case (r_phase)
            pmsfr_pkg::PH_START: begin
                // The command code is checked first so that it may equal the start byte.
                if (r_in_byte == r_cmd) begin
                    n_phase = pmsfr_pkg::PH_BODY;
                    n_count = 4'd0;
                    n_sum   = pmsfr_pkg::START_BYTE + r_in_byte;
                end else if (r_in_byte == pmsfr_pkg::START_BYTE) begin
                    n_phase = pmsfr_pkg::PH_START;
                end else begin
                    n_phase = pmsfr_pkg::PH_HUNT;
                end
            end
            pmsfr_pkg::PH_BODY: begin
                n_sum = r_sum + r_in_byte;
                if (r_count == pmsfr_pkg::STATUS_COUNT) begin
                    n_status = r_in_byte;
                end else if (r_count >= pmsfr_pkg::CONC_FIRST
                             && r_count <= pmsfr_pkg::CONC_LAST) begin
                    // Six data bytes shift in, most significant first.
                    n_conc = {r_conc[39:0], r_in_byte};
                end
                if (r_count >= pmsfr_pkg::BODY_LAST) begin
                    emit              = 1'b1;
                    n_phase           = pmsfr_pkg::PH_HUNT;
                    n_count           = 4'd0;
                    n_res.status_byte = r_status;
                    n_res.pm1_tenths  = r_conc[47:32];
                    n_res.pm25_tenths = r_conc[31:16];
                    n_res.pm10_tenths = r_conc[15:0];
                    n_res.checksum_ok = (n_sum == 8'd0);
                end else begin
                    n_count = r_count + 4'd1;
                end
            end
            default: begin
                n_phase = (r_in_byte == pmsfr_pkg::START_BYTE) ?
                          pmsfr_pkg::PH_START : pmsfr_pkg::PH_HUNT;
            end
        endcase
    end

    // The registered byte moves on unless it ends a frame while the result slot is full.
    assign advance    = r_in_valid && (!emit || !r_res_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pmsfr_pkg::PH_HUNT;
            r_count  <= 4'd0;
            r_sum    <= 8'd0;
            r_status <= 8'd0;
            r_conc   <= 48'd0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_status <= n_status;
            r_conc   <= n_conc;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance && emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_status_byte = r_res.status_byte;
    assign o_pm1_tenths  = r_res.pm1_tenths;
    assign o_pm25_tenths = r_res.pm25_tenths;
    assign o_pm10_tenths = r_res.pm10_tenths;
    assign o_checksum_ok = r_res.checksum_ok;

    // The body counter never passes the checksum byte.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pmsfr_pkg::BODY_LAST)
        else $error("body count out of range");

    // A nonzero body count only exists inside a frame body.
    a_count_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 4'd0) |-> (r_phase == pmsfr_pkg::PH_BODY))
        else $error("body count set outside a frame body");

    // A frame-ending byte blocked by a full result slot stays in the input register.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && emit && r_res_valid && !i_res_ready)
        |=> (r_in_valid && $stable(r_in_byte) && $stable(r_count)))
        else $error("blocked frame end was lost");

    // An empty input register always takes a new item.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_rx_ready)
        else $error("input stalled while empty");

    // A new result is loaded only when the previous one is gone or taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |-> (!r_res_valid || i_res_ready))
        else $error("result overwritten");

endmodule

[tb/pm_sensor_frame_receiver_top_tb.sv]
// Self-checking testbench for the particle sensor frame receiver top level.
module pm_sensor_frame_receiver_top_tb;
    import pmsfr_pkg::*;

    localparam int unsigned REG_UNUSED  = 1;
    localparam int unsigned PHASE_ITEMS = 180;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] rx;
        logic       fixed;
        t_result    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [7:0]  o_status_byte;
    logic [15:0] o_pm1_tenths;
    logic [15:0] o_pm25_tenths;
    logic [15:0] o_pm10_tenths;
    logic        o_checksum_ok;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the decoder state and of the command code register.
    logic [7:0]  cmd_code;
    logic [1:0]  hunt_phase;
    logic [3:0]  body_count;
    logic [7:0]  frame_sum;
    logic [7:0]  status_hold;
    logic [47:0] conc_hold;

    t_result     frame_q [$];
    int unsigned rx_accepted = 0;
    int unsigned frames_seen = 0;
    int unsigned bad_sums_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          tx_no_idle = 1'b0;
    bit          res_no_idle = 1'b0;
    bit          held_long = 1'b0;

    pm_sensor_frame_receiver_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_status_byte(o_status_byte),
        .o_pm1_tenths (o_pm1_tenths),
        .o_pm25_tenths(o_pm25_tenths),
        .o_pm10_tenths(o_pm10_tenths),
        .o_checksum_ok(o_checksum_ok),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advances the shadow decoder by one byte; returns 1 when the byte ends a frame.
    function automatic bit decode_byte(input logic [7:0] b, output t_result frame);
        int unsigned pos;
        frame = '0;
        if (hunt_phase == PH_START) begin
            // The command code is compared first so that a code of 0x81 still works.
            if (b == cmd_code) begin
                hunt_phase = PH_BODY;
                body_count = '0;
                frame_sum  = START_BYTE + b;
            end else if (b != START_BYTE) begin
                hunt_phase = PH_HUNT;
            end
            return 1'b0;
        end
        if (hunt_phase != PH_BODY) begin
            hunt_phase = (b == START_BYTE) ? PH_START : PH_HUNT;
            return 1'b0;
        end
        frame_sum = frame_sum + b;
        if (body_count == STATUS_COUNT) begin
            status_hold = b;
        end else if (body_count >= CONC_FIRST && body_count <= CONC_LAST) begin
            pos = body_count - CONC_FIRST;
            conc_hold[47 - 8 * pos -: 8] = b;
        end
        if (body_count >= BODY_LAST) begin
            frame.status_byte = status_hold;
            frame.pm1_tenths  = conc_hold[47:32];
            frame.pm25_tenths = conc_hold[31:16];
            frame.pm10_tenths = conc_hold[15:0];
            frame.checksum_ok = (frame_sum == 8'h00);
            hunt_phase = PH_HUNT;
            body_count = '0;
            return 1'b1;
        end
        body_count = body_count + 4'd1;
        return 1'b0;
    endfunction

    // Offers one byte, waits for its acceptance and records any frame it completes.
    task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                             input t_result want = '0);
        int unsigned gap;
        t_result     frame;
        gap = tx_no_idle ? 0 : idle_gap();
        if (gap != 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(negedge i_clk); while (!o_rx_ready);
        @(posedge i_clk);
        rx_accepted++;
        if (decode_byte(b, frame)) frame_q.push_back(fixed ? want : frame);
    endtask

    function automatic logic [7:0] body_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        if (r < 25) return START_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = START_BYTE + cmd_code;
        send_byte(START_BYTE);
        send_byte(cmd_code);
        for (int i = 0; i < 13; i++) begin
            b = body_byte();
            sum = sum + b;
            send_byte(b);
        end
        send_byte(good_sum ? 8'h00 - sum : body_byte());
    endtask

    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        // Bytes that end no frame may still sit in the input register.
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input int unsigned index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (index == int'(REG_COMMAND)) cmd_code = value[7:0];
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial begin : result_side
        int unsigned gap;
        i_res_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) res_no_idle = ~res_no_idle;
            if (!held_long && rx_accepted >= HOLD_AT) begin
                held_long = 1'b1;
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = res_no_idle ? 0 : idle_gap();
                if (gap != 0) begin
                    i_res_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_res_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (frame_q.size() == 0) begin
                $error("result item with no frame expected");
                mismatches++;
            end else begin
                want = frame_q.pop_front();
                frames_seen++;
                if (!o_checksum_ok) bad_sums_seen++;
                check_field("status_byte", want.status_byte, o_status_byte);
                check_field("pm1_tenths", want.pm1_tenths, o_pm1_tenths);
                check_field("pm25_tenths", want.pm25_tenths, o_pm25_tenths);
                check_field("pm10_tenths", want.pm10_tenths, o_pm10_tenths);
                check_field("checksum_ok", want.checksum_ok, o_checksum_ok);
            end
        end
    end

    initial begin : byte_side
        t_stim_row   rows [$];
        logic [7:0]  codes [$];
        logic [7:0]  junk;
        int unsigned kind;
        int unsigned phase_start;
        int unsigned drain;

        i_rst_n    <= 1'b0;
        i_rx_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cmd_code    = CMD_RESET;
        hunt_phase  = PH_HUNT;
        body_count  = '0;
        frame_sum   = '0;
        status_hold = '0;
        conc_hold   = '0;

        // A frame with a repeated start byte and extreme concentrations, then
        // a broken header and stray bytes while hunting.
        rows.push_back('{START_BYTE, 1'b0, '0});
        rows.push_back('{START_BYTE, 1'b0, '0});
        rows.push_back('{CMD_RESET, 1'b0, '0});
        rows.push_back('{8'hA5, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'h80, 1'b0, '0});
        rows.push_back('{8'h01, 1'b0, '0});
        rows.push_back('{8'h4C, 1'b1, '{8'hA5, 16'hFFFF, 16'h0000, 16'h8001, 1'b1}});
        rows.push_back('{START_BYTE, 1'b0, '0});
        rows.push_back('{8'h7F, 1'b0, '0});
        rows.push_back('{CMD_RESET, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_byte(rows[i].rx, rows[i].fixed, rows[i].want);

        codes = '{CMD_RESET, 8'h00, 8'hFF, START_BYTE, 8'h00, CMD_RESET};
        codes[4] = 8'($urandom_range(0, 255));
        foreach (codes[p]) begin
            wait_idle();
            if (p == 2) apb_write(REG_UNUSED, $urandom());
            apb_write(REG_COMMAND, ($urandom() & 32'hFFFF_FF00) | codes[p]);
            phase_start = rx_accepted;
            while (rx_accepted - phase_start < PHASE_ITEMS) begin
                tx_no_idle = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    send_frame($urandom_range(0, 99) < 85);
                end else if (kind < 80) begin
                    repeat ($urandom_range(1, 3)) send_byte(START_BYTE);
                    send_frame(1'b1);
                end else if (kind < 90) begin
                    do junk = 8'($urandom_range(0, 255));
                    while (junk == cmd_code || junk == START_BYTE);
                    send_byte(START_BYTE);
                    send_byte(junk);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        i_rx_valid <= 1'b0;
        drain = 0;
        while (frame_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $error("%0d expected frames never arrived", frame_q.size());
            mismatches++;
        end

        $display("tb: sent %0d bytes under %0d command code settings", rx_accepted,
                 codes.size() + 1);
        $display("tb: checked %0d frames, %0d of them with a failing checksum",
                 frames_seen, bad_sums_seen);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
sv/pmsfr_pkg.sv
sv/pm_sensor_frame_receiver_top.sv
tb/pm_sensor_frame_receiver_top_tb.sv
